### rtl/core/mfek_pkg.sv
package mfek_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_BITS = 6;
	localparam int COUNT_BITS = 7;
	localparam int CAP_BITS = 16;
	localparam int RES_BITS = 17;
	localparam int FLOW_BITS = 22;
	localparam int ADDR_BITS = 2 * NODE_BITS;

	localparam logic [RES_BITS-1:0] RES_MAX = '1;

	localparam logic [1:0] REG_NODE_COUNT = 2'd0;
	localparam logic [1:0] REG_SOURCE = 2'd1;
	localparam logic [1:0] REG_SINK = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_BFS_INIT,
		ST_Q_RD,
		ST_Q_WAIT,
		ST_SCAN,
		ST_CHECK,
		ST_T_RD,
		ST_T_GET,
		ST_T_MIN,
		ST_U_RD,
		ST_U_GET,
		ST_F_UPD,
		ST_B_UPD,
		ST_DONE
	} state_t;

endpackage

### rtl/core/max_flow_edmonds_karp.sv
// Edges are taken one per cycle while the block is idle into a 64 x 64 residual
// memory. The edge marked tlast starts Edmonds-Karp: each breadth-first search has an
// init step, a queue read and wait step per dequeued node and a scan and check step
// per scanned node; each augmenting path takes read, get and min steps per hop to find
// its bottleneck, then read, get, forward and backward update steps to update it,
// on one read and one write port of the residual memory. The result goes to an output
// register; the memory is cleared one entry per cycle before the next edge is taken;
// the same clearing pass runs after reset. Configuration writes are always taken.
module max_flow_edmonds_karp
	import mfek_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // from_node[5:0], to_node[11:6], capacity[27:12]
	input  logic        s_axis_tlast,  // last_edge
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // net_flow[21:0]
);

	state_t state_q, state_d;

	logic [ADDR_BITS-1:0] clr_q;
	logic [COUNT_BITS-1:0] node_count_q, n_eff;
	logic [NODE_BITS-1:0] source_q, sink_q, u_q, v_q;
	logic [COUNT_BITS-1:0] head_q, tail_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [RES_BITS-1:0] bn_q;
	logic [FLOW_BITS-1:0] flow_q, out_data_q;
	logic out_valid_q;

	logic [RES_BITS-1:0] res_mem [2**ADDR_BITS];
	logic [RES_BITS-1:0] res_rd_q;
	logic [NODE_BITS-1:0] par_mem [MAX_NODES];
	logic [NODE_BITS-1:0] par_rd_q;
	logic [NODE_BITS-1:0] que_mem [MAX_NODES];
	logic [NODE_BITS-1:0] que_rd_q;

	logic res_we;
	logic [ADDR_BITS-1:0] res_waddr, res_raddr;
	logic [RES_BITS-1:0] res_wdata;
	logic in_fire, found, bad_nodes, scan_last;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {2'b00, out_data_q};

	assign n_eff = (node_count_q > COUNT_BITS'(MAX_NODES)) ? COUNT_BITS'(MAX_NODES)
		: node_count_q;
	assign bad_nodes = ({1'b0, source_q} >= n_eff) || ({1'b0, sink_q} >= n_eff)
		|| (source_q == sink_q);
	assign found = !visited_q[v_q] && (res_rd_q != '0);
	assign scan_last = ({1'b0, v_q} == n_eff - COUNT_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		res_we = 1'b0;
		res_waddr = {u_q, v_q};
		res_wdata = '0;
		res_raddr = {u_q, v_q};
		unique case (state_q)
			ST_CLEAR: begin
				res_we = 1'b1;
				res_waddr = clr_q;
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire) begin
					res_we = 1'b1;
					res_waddr = {s_axis_tdata[5:0], s_axis_tdata[11:6]};
					res_wdata = {1'b0, s_axis_tdata[27:12]};
					if (s_axis_tlast) state_d = ST_START;
				end
			end
			ST_START:    state_d = bad_nodes ? ST_DONE : ST_BFS_INIT;
			ST_BFS_INIT: state_d = ST_Q_RD;
			ST_Q_RD:     state_d = (head_q == tail_q) ? ST_DONE : ST_Q_WAIT;
			ST_Q_WAIT:   state_d = ST_SCAN;
			ST_SCAN:     state_d = ST_CHECK;
			ST_CHECK: begin
				if (found && v_q == sink_q) state_d = ST_T_RD;
				else if (scan_last) state_d = ST_Q_RD;
				else state_d = ST_SCAN;
			end
			ST_T_RD: state_d = ST_T_GET;
			ST_T_GET: begin
				res_raddr = {par_rd_q, v_q};
				state_d = ST_T_MIN;
			end
			ST_T_MIN: state_d = (u_q == source_q) ? ST_U_RD : ST_T_RD;
			ST_U_RD:  state_d = ST_U_GET;
			ST_U_GET: begin
				res_raddr = {par_rd_q, v_q};
				state_d = ST_F_UPD;
			end
			ST_F_UPD: begin
				res_we = 1'b1;
				res_waddr = {u_q, v_q};
				res_wdata = res_rd_q - bn_q;
				res_raddr = {v_q, u_q};
				state_d = ST_B_UPD;
			end
			ST_B_UPD: begin
				res_we = 1'b1;
				res_waddr = {v_q, u_q};
				res_wdata = res_rd_q + bn_q;
				state_d = (u_q == source_q) ? ST_BFS_INIT : ST_U_RD;
			end
			ST_DONE: if (!out_valid_q) state_d = ST_CLEAR;
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (res_we) res_mem[res_waddr] <= res_wdata;
		res_rd_q <= res_mem[res_raddr];
		par_rd_q <= par_mem[v_q];
		que_rd_q <= que_mem[head_q[NODE_BITS-1:0]];
		if (state_q == ST_BFS_INIT) que_mem[0] <= source_q;
		if (state_q == ST_CHECK && found) begin
			par_mem[v_q] <= u_q;
			if (v_q != sink_q && tail_q < COUNT_BITS'(MAX_NODES))
				que_mem[tail_q[NODE_BITS-1:0]] <= v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			node_count_q <= COUNT_BITS'(MAX_NODES);
			source_q <= '0;
			sink_q <= NODE_BITS'(1);
			head_q <= '0;
			tail_q <= '0;
			visited_q <= '0;
			flow_q <= '0;
			out_valid_q <= 1'b0;
			u_q <= '0;
			v_q <= '0;
			bn_q <= '0;
			out_data_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_NODE_COUNT: node_count_q <= cfg_data;
					REG_SOURCE:     source_q <= cfg_data[NODE_BITS-1:0];
					REG_SINK:       sink_q <= cfg_data[NODE_BITS-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + ADDR_BITS'(1);
				ST_START: flow_q <= '0;
				ST_BFS_INIT: begin
					visited_q <= {{(MAX_NODES-1){1'b0}}, 1'b1} << source_q;
					head_q <= '0;
					tail_q <= COUNT_BITS'(1);
				end
				ST_Q_RD: if (head_q != tail_q) head_q <= head_q + COUNT_BITS'(1);
				ST_Q_WAIT: begin
					u_q <= que_rd_q;
					v_q <= '0;
				end
				ST_CHECK: begin
					if (found && v_q == sink_q) begin
						bn_q <= RES_MAX;
					end else begin
						if (found) begin
							visited_q[v_q] <= 1'b1;
							if (tail_q < COUNT_BITS'(MAX_NODES)) tail_q <= tail_q + COUNT_BITS'(1);
						end
						if (!scan_last) v_q <= v_q + NODE_BITS'(1);
					end
				end
				ST_T_GET, ST_U_GET: u_q <= par_rd_q;
				ST_T_MIN: begin
					if (res_rd_q < bn_q) bn_q <= res_rd_q;
					v_q <= (u_q == source_q) ? sink_q : u_q;
				end
				ST_B_UPD: begin
					v_q <= u_q;
					if (u_q == source_q) flow_q <= flow_q + FLOW_BITS'(bn_q);
				end
				ST_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_data_q <= flow_q;
						clr_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
